>>> hdl/bffa_pkg.sv
package bffa_pkg;

  localparam int WORD_BITS  = 8;
  localparam int INDEX_BITS = 13;
  localparam int LIMIT_BITS = 14;
  localparam int MODE_BITS  = 2;
  localparam int STAT_BITS  = 2;

  // bit select within a map word
  localparam logic [2:0] BIT_SEL_MASK = 3'b111;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 14'd8192;

  localparam logic [MODE_BITS-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_CLAIM   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_RELEASE = 2'd2;

  localparam logic [STAT_BITS-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_IN_USE = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_RANGE  = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_FULL   = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_MOD   = 6'b001000,
    S_SCAN  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

endpackage

>>> hdl/bitmap_first_fit_allocator.sv
// First-fit bitmap allocator: one usage bit per entry, eight entries per map word.
//
// Request channel (req_valid / req_stall, fields mode and index): a beat is
// taken when req_valid is high and req_stall low. Allocate returns the lowest
// free entry below the limit, claim sets a named entry, release clears one.
// Response channel (rsp_valid / rsp_stall, fields result_index and status):
// exactly one beat per request, in request order.
// Config channel (cfg_valid / cfg_ready, entry_limit): always ready; write it
// only while no request is in flight.
//
// Claim/release pass from accept to response valid through read, modify-write
// and the output register; range errors go straight to the output register.
// Allocate scans the map one word per cycle through the single memory read port
// and stops at the first word that holds a free entry below the limit. One
// request is in service at a time; the next is taken once the previous result
// has been moved into the output register, even while that result is stalled.
//
// Reset: a clearing pass writes every map word (1024 at the default) to zero,
// with req_stall high. entry_limit resets to 8192.
// A stalled response simply holds; the request side stalls behind it.
module bitmap_first_fit_allocator #(
  parameter int MAP_BITS = 8192
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [bffa_pkg::MODE_BITS-1:0]      mode,
  input  logic [bffa_pkg::INDEX_BITS-1:0]     index,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [bffa_pkg::INDEX_BITS-1:0]     result_index,
  output logic [bffa_pkg::STAT_BITS-1:0]      status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bffa_pkg::LIMIT_BITS-1:0]     entry_limit
);

  localparam int MAP_WORDS = (MAP_BITS + 7) / 8;
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  // configured limit; capped to the map size inside the controller
  logic [bffa_pkg::LIMIT_BITS-1:0] limit;

  bffa_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  bffa_pkg::word_t    wr_data;
  bffa_pkg::word_t    rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= bffa_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= entry_limit;
    end
  end

  bffa_ctrl #(
    .MAP_BITS (MAP_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .lim          (limit),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .mode         (mode),
    .index        (index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_index (result_index),
    .status       (status),
    .mem_ctl      (mem_ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_data      (rd_data)
  );

  // usage map: one write port, one registered read port
  bffa_map_ram #(
    .MAP_BITS (MAP_BITS)
  ) u_map (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

>>> hdl/bffa_map_ram.sv
module bffa_map_ram #(
  parameter int MAP_BITS = 8192,
  localparam int MAP_WORDS = (MAP_BITS + 7) / 8,
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                    clk,
  input  bffa_pkg::mem_ctl_t      mem_ctl,
  input  logic [AW-1:0]           rd_addr,
  input  logic [AW-1:0]           wr_addr,
  input  bffa_pkg::word_t         wr_data,
  output bffa_pkg::word_t         rd_data
);

  bffa_pkg::word_t mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/bffa_ctrl.sv
module bffa_ctrl #(
  parameter int MAP_BITS = 8192,
  localparam int MAP_WORDS = (MAP_BITS + 7) / 8,
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [bffa_pkg::LIMIT_BITS-1:0]     lim,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [bffa_pkg::MODE_BITS-1:0]      mode,
  input  logic [bffa_pkg::INDEX_BITS-1:0]     index,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [bffa_pkg::INDEX_BITS-1:0]     result_index,
  output logic [bffa_pkg::STAT_BITS-1:0]      status,
  output bffa_pkg::mem_ctl_t                  mem_ctl,
  output logic [AW-1:0]                       rd_addr,
  output logic [AW-1:0]                       wr_addr,
  output bffa_pkg::word_t                     wr_data,
  input  bffa_pkg::word_t                     rd_data
);

  localparam int CW = $clog2(MAP_WORDS + 1);
  localparam int ZW = (CW + 3 > bffa_pkg::LIMIT_BITS) ? CW + 3 : bffa_pkg::LIMIT_BITS;
  localparam int LIM_CAP = (MAP_BITS < 16383) ? MAP_BITS : 16383;
  localparam int LW = bffa_pkg::LIMIT_BITS;
  localparam int IW = bffa_pkg::INDEX_BITS;

  bffa_pkg::state_t state;

  logic [AW-1:0]                     clr_ptr;
  logic [bffa_pkg::MODE_BITS-1:0]    mode_q;
  logic [IW-1:0]                     idx_q;
  logic [LW-1:0]                     lim_q;
  logic [CW-1:0]                     nwords_q;
  logic [CW-1:0]                     rd_ptr;
  logic [CW-1:0]                     chk_ptr;
  logic                              chk_valid;
  logic [IW-1:0]                     res_q;
  logic [bffa_pkg::STAT_BITS-1:0]    st_q;

  logic [LW-1:0]         lim_eff;
  logic                  accept;
  logic                  issue;
  logic                  out_load;
  logic [AW-1:0]         idx_word;
  bffa_pkg::word_t       bit_mask;
  logic                  hit;
  logic                  write_mod;
  bffa_pkg::word_t       mod_data;
  bffa_pkg::word_t       valid_mask;
  bffa_pkg::word_t       free_bits;
  logic                  found;
  logic [2:0]            found_bit;
  bffa_pkg::word_t       found_mask;
  logic [ZW-1:0]         base;

  assign lim_eff = (lim > LW'(LIM_CAP)) ? LW'(LIM_CAP) : lim;
  assign req_stall = (state != bffa_pkg::S_IDLE);
  assign accept = req_valid && (state == bffa_pkg::S_IDLE);
  assign issue = (state == bffa_pkg::S_SCAN) && (rd_ptr < nwords_q);
  assign out_load = (state == bffa_pkg::S_FIN) && (!rsp_valid || !rsp_stall);

  assign idx_word = AW'(idx_q >> 3);
  assign bit_mask = bffa_pkg::word_t'(8'b1 << (idx_q[2:0] & bffa_pkg::BIT_SEL_MASK));
  assign hit = (rd_data & bit_mask) != '0;
  assign write_mod = !((mode_q == bffa_pkg::MODE_CLAIM) && hit);
  assign mod_data = (mode_q == bffa_pkg::MODE_CLAIM) ? (rd_data | bit_mask)
                                                     : (rd_data & ~bit_mask);

  // lowest free bit of the word under check, entries at or above the limit masked
  assign base = ZW'({chk_ptr, 3'b000});

  always_comb begin
    valid_mask = '0;
    for (int b = 0; b < bffa_pkg::WORD_BITS; b++) begin
      valid_mask[b] = (base + ZW'(b)) < ZW'(lim_q);
    end
  end

  assign free_bits = ~rd_data & valid_mask;
  assign found = free_bits != '0;

  always_comb begin
    found_bit = '0;
    for (int b = bffa_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        found_bit = 3'(b);
      end
    end
  end

  assign found_mask = bffa_pkg::word_t'(8'b1 << found_bit);

  always_comb begin
    mem_ctl = '0;
    rd_addr = '0;
    wr_addr = '0;
    wr_data = '0;
    case (state)
      bffa_pkg::S_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr = clr_ptr;
      end
      bffa_pkg::S_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr = idx_word;
      end
      bffa_pkg::S_MOD: begin
        mem_ctl.wr_en = write_mod;
        wr_addr = idx_word;
        wr_data = mod_data;
      end
      bffa_pkg::S_SCAN: begin
        mem_ctl.rd_en = issue;
        rd_addr = rd_ptr[AW-1:0];
        mem_ctl.wr_en = chk_valid && found;
        wr_addr = chk_ptr[AW-1:0];
        wr_data = rd_data | found_mask;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bffa_pkg::S_CLEAR;
      clr_ptr <= '0;
      rsp_valid <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      if (out_load) begin
        rsp_valid <= 1'b1;
        result_index <= res_q;
        status <= st_q;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        bffa_pkg::S_CLEAR: begin
          clr_ptr <= clr_ptr + AW'(1);
          if (clr_ptr == AW'(MAP_WORDS - 1)) begin
            state <= bffa_pkg::S_IDLE;
          end
        end
        bffa_pkg::S_IDLE: begin
          if (accept) begin
            mode_q <= mode;
            idx_q <= index;
            lim_q <= lim_eff;
            nwords_q <= CW'(((LW + 1)'(lim_eff) + (LW + 1)'(7)) >> 3);
            rd_ptr <= '0;
            chk_valid <= 1'b0;
            res_q <= '0;
            case (mode)
              bffa_pkg::MODE_ALLOC: begin
                if (lim_eff == '0) begin
                  st_q <= bffa_pkg::ST_FULL;
                  state <= bffa_pkg::S_FIN;
                end else begin
                  state <= bffa_pkg::S_SCAN;
                end
              end
              bffa_pkg::MODE_CLAIM, bffa_pkg::MODE_RELEASE: begin
                if (LW'(index) >= lim_eff) begin
                  st_q <= bffa_pkg::ST_RANGE;
                  state <= bffa_pkg::S_FIN;
                end else begin
                  state <= bffa_pkg::S_RD;
                end
              end
              default: begin
                st_q <= bffa_pkg::ST_RANGE;
                state <= bffa_pkg::S_FIN;
              end
            endcase
          end
        end
        bffa_pkg::S_RD: begin
          state <= bffa_pkg::S_MOD;
        end
        bffa_pkg::S_MOD: begin
          if (write_mod) begin
            st_q <= bffa_pkg::ST_OK;
            res_q <= idx_q;
          end else begin
            st_q <= bffa_pkg::ST_IN_USE;
            res_q <= '0;
          end
          state <= bffa_pkg::S_FIN;
        end
        bffa_pkg::S_SCAN: begin
          if (issue) begin
            rd_ptr <= rd_ptr + CW'(1);
          end
          chk_valid <= issue;
          chk_ptr <= rd_ptr;
          if (chk_valid) begin
            if (found) begin
              res_q <= IW'(base + ZW'(found_bit));
              st_q <= bffa_pkg::ST_OK;
              state <= bffa_pkg::S_FIN;
            end else if (!issue) begin
              res_q <= '0;
              st_q <= bffa_pkg::ST_FULL;
              state <= bffa_pkg::S_FIN;
            end
          end
        end
        bffa_pkg::S_FIN: begin
          if (out_load) begin
            state <= bffa_pkg::S_IDLE;
          end
        end
        default: begin
          state <= bffa_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_BITS = 8192;
  localparam int HALF_PERIOD = 6;

  // mode 3 is not a defined operation; the block answers it with a range error
  localparam logic [bffa_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  // Slowest legal item is a full-map scan plus sender gaps and receiver stalls,
  // over ~2000 items. Margin on top.
  localparam int LIMIT_CYCLES = 10_000_000;
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off to back up the block
  localparam int TAIL_CYCLES = 40;    // quiet time after the last beat
  localparam int NUM_PHASES = 10;

  typedef struct {
    logic [bffa_pkg::INDEX_BITS-1:0] idx;
    logic [bffa_pkg::STAT_BITS-1:0] st;
  } alloc_result_t;

  // one row of the directed table; a row with new_lim drains and rewrites the limit first
  typedef struct {
    bit new_lim;
    logic [bffa_pkg::LIMIT_BITS-1:0] lim;
    logic [bffa_pkg::MODE_BITS-1:0] m;
    logic [bffa_pkg::INDEX_BITS-1:0] ix;
    bit typed;
    logic [bffa_pkg::INDEX_BITS-1:0] want_idx;
    logic [bffa_pkg::STAT_BITS-1:0] want_st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [bffa_pkg::MODE_BITS-1:0] mode = bffa_pkg::MODE_ALLOC;
  logic [bffa_pkg::INDEX_BITS-1:0] index = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [bffa_pkg::INDEX_BITS-1:0] result_index;
  logic [bffa_pkg::STAT_BITS-1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bffa_pkg::LIMIT_BITS-1:0] entry_limit = bffa_pkg::LIMIT_RESET;

  // typed expectation riding along with the request beat (directed rows only)
  logic typed_on = 1'b0;
  logic [bffa_pkg::INDEX_BITS-1:0] typed_idx = '0;
  logic [bffa_pkg::STAT_BITS-1:0] typed_st = bffa_pkg::ST_OK;

  // shadow of the block: usage bits and the current limit register
  bit used_map [MAP_BITS];
  logic [bffa_pkg::LIMIT_BITS-1:0] limit_shadow = bffa_pkg::LIMIT_RESET;
  alloc_result_t pending_results [$];

  int unsigned reqs_taken = 0;
  int unsigned rsps_seen = 0;
  int unsigned err_count = 0;
  int unsigned limit_writes = 0;
  int unsigned status_seen [4];
  int unsigned cycles = 0;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  bit hold_req = 1'b0;

  dir_row_t dir_tab [$];

  bitmap_first_fit_allocator dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .mode(mode),
    .index(index),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .result_index(result_index),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .entry_limit(entry_limit)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic flag_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("mismatch %0d at cycle %0d: %s got %0d expected %0d",
             err_count, cycles, what, got, want);
  endtask

  // First-fit semantics: effective limit is min(limit, MAP_BITS); every
  // failure returns index 0; releasing a free entry still reports ok.
  function automatic alloc_result_t apply_request(
      input logic [bffa_pkg::MODE_BITS-1:0] m,
      input logic [bffa_pkg::INDEX_BITS-1:0] ix);
    alloc_result_t r;
    int unsigned eff;
    bit found;
    eff = (limit_shadow > MAP_BITS) ? MAP_BITS : limit_shadow;
    r.idx = '0;
    r.st = bffa_pkg::ST_OK;
    found = 1'b0;
    case (m)
      bffa_pkg::MODE_ALLOC: begin
        r.st = bffa_pkg::ST_FULL;
        for (int i = 0; i < eff; i++) begin
          if (!found && !used_map[i]) begin
            used_map[i] = 1'b1;
            r.idx = bffa_pkg::INDEX_BITS'(i);
            r.st = bffa_pkg::ST_OK;
            found = 1'b1;
          end
        end
      end
      bffa_pkg::MODE_CLAIM: begin
        if (ix >= eff) begin
          r.st = bffa_pkg::ST_RANGE;
        end else if (used_map[ix]) begin
          r.st = bffa_pkg::ST_IN_USE;
        end else begin
          used_map[ix] = 1'b1;
          r.idx = ix;
        end
      end
      bffa_pkg::MODE_RELEASE: begin
        if (ix >= eff) begin
          r.st = bffa_pkg::ST_RANGE;
        end else begin
          used_map[ix] = 1'b0;
          r.idx = ix;
        end
      end
      default: r.st = bffa_pkg::ST_RANGE;
    endcase
    return r;
  endfunction

  // Monitor: all sampling happens at the rising edge, before the edge's
  // nonblocking updates land. Responses are checked ahead of new requests
  // so a beat accepted on the same edge can never match its own result.
  always @(posedge clk) begin : beat_monitor
    alloc_result_t got_exp;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        rsps_seen++;
        status_seen[status]++;
        if (pending_results.size() == 0) begin
          flag_mismatch("response with nothing pending, index", result_index, -1);
        end else begin
          got_exp = pending_results.pop_front();
          if (result_index !== got_exp.idx)
            flag_mismatch("result_index", result_index, got_exp.idx);
          if (status !== got_exp.st)
            flag_mismatch("status", status, got_exp.st);
        end
      end
      if (cfg_valid && cfg_ready) begin
        limit_shadow = entry_limit;
        limit_writes++;
      end
      if (req_valid && !req_stall) begin
        got_exp = apply_request(mode, index);
        // directed rows pin the answer by hand; the shadow map still advances
        if (typed_on) begin
          got_exp.idx = typed_idx;
          got_exp.st = typed_st;
        end
        pending_results.push_back(got_exp);
      end
    end
  end

  // Receiver: random stall per cycle, plus one long hold-off on request.
  // The hold starts once a response shows up so the block is genuinely full.
  initial begin : rsp_side
    forever begin
      @(posedge clk);
      if (hold_req && rsp_valid) begin
        hold_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Offer one request beat. valid stays high across back-to-back beats and
  // only drops for a sender gap, so it never toggles twice in one step.
  task automatic offer(input logic [bffa_pkg::MODE_BITS-1:0] m,
                       input logic [bffa_pkg::INDEX_BITS-1:0] ix,
                       input bit pin, input logic [bffa_pkg::INDEX_BITS-1:0] p_idx,
                       input logic [bffa_pkg::STAT_BITS-1:0] p_st);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    mode <= m;
    index <= ix;
    typed_on <= pin;
    typed_idx <= p_idx;
    typed_st <= p_st;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    reqs_taken++;
  endtask

  // Wait until every accepted beat has its response. Every request yields
  // exactly one result, so the block is idle once the counts meet.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (rsps_seen < reqs_taken) @(posedge clk);
  endtask

  task automatic write_limit(input logic [bffa_pkg::LIMIT_BITS-1:0] v);
    cfg_valid <= 1'b1;
    entry_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic dir_row_t mk_row(input bit nl, input int lim,
                                      input logic [bffa_pkg::MODE_BITS-1:0] m,
                                      input int ix, input bit typed, input int w_idx,
                                      input logic [bffa_pkg::STAT_BITS-1:0] w_st);
    dir_row_t r;
    r.new_lim = nl;
    r.lim = bffa_pkg::LIMIT_BITS'(lim);
    r.m = m;
    r.ix = bffa_pkg::INDEX_BITS'(ix);
    r.typed = typed;
    r.want_idx = bffa_pkg::INDEX_BITS'(w_idx);
    r.want_st = w_st;
    return r;
  endfunction

  // Random request for the current limit. Allocate leads so small maps fill
  // up and report full; indices favor the valid range and its upper edge,
  // with a share of fully random 13-bit values for range errors.
  task automatic random_request(input int unsigned eff);
    logic [bffa_pkg::MODE_BITS-1:0] m;
    logic [bffa_pkg::INDEX_BITS-1:0] ix;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) m = bffa_pkg::MODE_ALLOC;
    else if (pick < 70) m = bffa_pkg::MODE_CLAIM;
    else if (pick < 95) m = bffa_pkg::MODE_RELEASE;
    else m = MODE_UNUSED;
    pick = $urandom_range(0, 99);
    if (eff > 0 && pick < 55) ix = bffa_pkg::INDEX_BITS'($urandom_range(0, eff - 1));
    else if (eff > 0 && pick < 70) ix = bffa_pkg::INDEX_BITS'(eff - $urandom_range(0, 1));
    else ix = bffa_pkg::INDEX_BITS'($urandom_range(0, MAP_BITS - 1));
    offer(m, ix, 1'b0, '0, bffa_pkg::ST_OK);
  endtask

  initial begin : stimulus
    int unsigned phase_lim [NUM_PHASES];
    int unsigned phase_len [NUM_PHASES];
    int unsigned eff;
    dir_row_t row;

    // limits: small maps that fill, zero, clamped 14-bit max, the reset value
    phase_lim = '{24, 9, 16383, 0, 130, 8, 8192, 64, 1, 2000};
    phase_len = '{220, 200, 200, 120, 200, 220, 200, 200, 190, 200};

    // Directed walk from reset (limit 8192, empty map). Rows with a typed
    // answer are obvious from the map contents; the rest use the shadow.
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_ALLOC, 0, 1, 0, bffa_pkg::ST_OK));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_ALLOC, 8191, 1, 1, bffa_pkg::ST_OK));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_CLAIM, 8191, 1, 8191, bffa_pkg::ST_OK));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_CLAIM, 8191, 1, 0, bffa_pkg::ST_IN_USE));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_RELEASE, 8191, 1, 8191, bffa_pkg::ST_OK));
    // already free
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_RELEASE, 8191, 1, 8191, bffa_pkg::ST_OK));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_CLAIM, 0, 1, 0, bffa_pkg::ST_IN_USE));
    dir_tab.push_back(mk_row(0, 0, MODE_UNUSED, 8191, 1, 0, bffa_pkg::ST_RANGE));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_RELEASE, 0, 1, 0, bffa_pkg::ST_OK));
    // refills the hole
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_ALLOC, 0, 1, 0, bffa_pkg::ST_OK));
    // index == limit
    dir_tab.push_back(mk_row(1, 4, bffa_pkg::MODE_CLAIM, 4, 1, 0, bffa_pkg::ST_RANGE));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_RELEASE, 5, 1, 0, bffa_pkg::ST_RANGE));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_ALLOC, 0, 1, 2, bffa_pkg::ST_OK));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_ALLOC, 0, 1, 3, bffa_pkg::ST_OK));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_ALLOC, 0, 1, 0, bffa_pkg::ST_FULL));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_CLAIM, 8191, 1, 0, bffa_pkg::ST_RANGE));
    // zero limit
    dir_tab.push_back(mk_row(1, 0, bffa_pkg::MODE_ALLOC, 0, 1, 0, bffa_pkg::ST_FULL));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_CLAIM, 0, 1, 0, bffa_pkg::ST_RANGE));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_RELEASE, 0, 1, 0, bffa_pkg::ST_RANGE));
    // clamped to map
    dir_tab.push_back(mk_row(1, 16383, bffa_pkg::MODE_CLAIM, 8191, 1, 8191, bffa_pkg::ST_OK));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_ALLOC, 0, 0, 0, bffa_pkg::ST_OK));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_RELEASE, 13'h1555, 0, 0, bffa_pkg::ST_OK));
    // bits above stay
    dir_tab.push_back(mk_row(1, 1, bffa_pkg::MODE_RELEASE, 0, 1, 0, bffa_pkg::ST_OK));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_ALLOC, 0, 1, 0, bffa_pkg::ST_OK));
    dir_tab.push_back(mk_row(0, 0, bffa_pkg::MODE_ALLOC, 0, 1, 0, bffa_pkg::ST_FULL));

    // reset once; the block then runs its clearing pass with req_stall high
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_limit(bffa_pkg::LIMIT_RESET);

    // sender idles 30%, receiver 78% for the directed part and phases 0..3
    snd_idle_pct = 30;
    rcv_idle_pct = 78;
    foreach (dir_tab[k]) begin
      row = dir_tab[k];
      if (row.new_lim) begin
        drain();
        write_limit(row.lim);
      end
      offer(row.m, row.ix, row.typed, row.want_idx, row.want_st);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_limit(bffa_pkg::LIMIT_BITS'(phase_lim[p]));
      if (p == 4) begin
        snd_idle_pct = 78;
        rcv_idle_pct = 30;
      end else if (p == 7) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // one long back-pressure stretch while requests keep coming
      if (p == 1) hold_req = 1'b1;
      eff = (phase_lim[p] > MAP_BITS) ? MAP_BITS : phase_lim[p];
      repeat (phase_len[p]) random_request(eff);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("results never returned, count", 0, pending_results.size());

    $display("covered %0d requests under %0d limit writes", reqs_taken, limit_writes);
    $display("responses: ok %0d, in use %0d, out of range %0d, full %0d",
             status_seen[bffa_pkg::ST_OK], status_seen[bffa_pkg::ST_IN_USE],
             status_seen[bffa_pkg::ST_RANGE], status_seen[bffa_pkg::ST_FULL]);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/bffa_pkg.sv
hdl/bffa_map_ram.sv
hdl/bffa_ctrl.sv
hdl/bitmap_first_fit_allocator.sv
tb/tb_top.sv
